>>> src/prtcl_pkg.sv
package prtcl_pkg;

  typedef struct packed {
    logic signed [15:0] phase_a_current;
    logic signed [15:0] phase_b_current;
    logic signed [15:0] phase_c_current;
    logic               currents_valid;
    logic [15:0]        bus_voltage;
    logic               bus_voltage_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] modulation;
    logic signed [15:0] bus_current;
    logic signed [15:0] filtered_beta;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] current_target;
    logic [15:0]        integral_gain;
    logic [15:0]        filter_gain;
    logic [14:0]        voltage_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_CURRENT_TARGET = 2'd0,
    REG_INTEGRAL_GAIN  = 2'd1,
    REG_FILTER_GAIN    = 2'd2,
    REG_VOLTAGE_LIMIT  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_FAULT       = 2'd1,
    STATUS_BUS_INVALID = 2'd2
  } status_code_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CAPTURE,
    OP_ALPHA,
    OP_BETA,
    OP_INT_MUL,
    OP_INT_ADD,
    OP_FILT_MUL,
    OP_FILT_ADD,
    OP_CHECK,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MOD,
    OP_BUS,
    OP_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic skip_div;
    logic fault_latched;
  } dp_stat_t;

  // 1/sqrt(3) in Q0.16
  localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
  // ceil(2^21 / 3), exact floor(n/3) for n below 2^21
  localparam logic [19:0] DIV3_RECIP = 20'd699051;
  localparam int          DIV3_SHIFT = 21;
  // quotient bits produced by the modulation divider
  localparam int          DIV_STEPS  = 16;

endpackage

>>> src/prtcl_regs.sv
module prtcl_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output prtcl_pkg::cfg_t     cfg
);

  prtcl_pkg::reg_index_t idx;
  logic                  wr;

  assign idx = prtcl_pkg::reg_index_t'(paddr[3:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_target <= '0;
      cfg.integral_gain  <= '0;
      cfg.filter_gain    <= '0;
      cfg.voltage_limit  <= 15'h7fff;
    end else if (wr) begin
      unique case (idx)
        prtcl_pkg::REG_CURRENT_TARGET: cfg.current_target <= pwdata[15:0];
        prtcl_pkg::REG_INTEGRAL_GAIN:  cfg.integral_gain  <= pwdata[15:0];
        prtcl_pkg::REG_FILTER_GAIN:    cfg.filter_gain    <= pwdata[15:0];
        prtcl_pkg::REG_VOLTAGE_LIMIT:  cfg.voltage_limit  <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      prtcl_pkg::REG_CURRENT_TARGET: prdata = {16'd0, cfg.current_target};
      prtcl_pkg::REG_INTEGRAL_GAIN:  prdata = {16'd0, cfg.integral_gain};
      prtcl_pkg::REG_FILTER_GAIN:    prdata = {16'd0, cfg.filter_gain};
      prtcl_pkg::REG_VOLTAGE_LIMIT:  prdata = {17'd0, cfg.voltage_limit};
    endcase
  end

endmodule

>>> src/prtcl_dp.sv
module prtcl_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  prtcl_pkg::cfg_t      cfg,
  input  prtcl_pkg::in_item_t  in_item,
  input  prtcl_pkg::dp_cmd_t   cmd,
  output prtcl_pkg::dp_stat_t  stat,
  output prtcl_pkg::out_item_t out_item
);

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) return 16'sh7fff;
    else if (v < -40'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    if (v > 40'sd8388607) return 24'sh7fffff;
    else if (v < -40'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  // captured item and working registers
  prtcl_pkg::in_item_t    item;
  logic signed [15:0]     alpha;
  logic signed [15:0]     beta;
  logic signed [33:0]     inc;
  logic signed [41:0]     fprod;
  logic [23:0]            mag;
  logic [31:0]            num;
  logic [16:0]            rem;
  logic [15:0]            quo;
  logic                   ovf;
  logic                   fault_now;
  logic                   div_en;
  prtcl_pkg::status_code_t status_code;
  logic signed [15:0]     bus_i;

  // loop state
  logic signed [23:0]     test_voltage;
  logic signed [23:0]     beta_filter;
  logic signed [15:0]     alpha_current;
  logic signed [15:0]     last_modulation;
  logic                   fault_latched;

  // clarke alpha: round(x / 3) away from zero through a reciprocal
  logic signed [18:0] clarke_x;
  logic [17:0]        div3_n;
  logic [37:0]        div3_p;
  logic [16:0]        div3_q;
  logic signed [15:0] alpha_val;

  assign clarke_x = (19'(item.phase_a_current) <<< 1) - 19'(item.phase_b_current)
                    - 19'(item.phase_c_current);
  assign div3_n   = clarke_x[18] ? 18'(-clarke_x) + 18'd1 : 18'(clarke_x) + 18'd1;
  assign div3_p   = 38'(div3_n) * 38'(prtcl_pkg::DIV3_RECIP);
  assign div3_q   = div3_p[prtcl_pkg::DIV3_SHIFT +: 17];

  always_comb begin
    if (clarke_x[18]) alpha_val = (div3_q > 17'd32768) ? 16'sh8000 : 16'(-div3_q);
    else              alpha_val = (div3_q > 17'd32767) ? 16'sh7fff : 16'(div3_q);
  end

  // clarke beta
  logic signed [16:0] beta_d;
  logic signed [17:0] beta_k;
  logic signed [34:0] beta_p;

  assign beta_d = 17'(item.phase_b_current) - 17'(item.phase_c_current);
  assign beta_k = signed'({2'b00, prtcl_pkg::INV_SQRT3_Q16});
  assign beta_p = 35'(beta_d) * 35'(beta_k) + 35'sd32768;

  // integrator
  logic signed [16:0] err;
  logic signed [16:0] ki;
  logic signed [34:0] tv_sum;

  assign err    = 17'(cfg.current_target) - 17'(alpha);
  assign ki     = signed'({1'b0, cfg.integral_gain});
  assign tv_sum = 35'(test_voltage) + 35'(inc);

  // beta filter
  logic signed [24:0] fdiff;
  logic signed [16:0] kf;
  logic signed [41:0] fround;
  logic signed [26:0] bf_sum;

  assign fdiff  = (25'(beta) <<< 8) - 25'(beta_filter);
  assign kf     = signed'({1'b0, cfg.filter_gain});
  assign fround = fprod + 42'sd32768;
  assign bf_sum = 27'($signed(fround[41:16])) + 27'(beta_filter);

  // fault check and modulation numerator 384 * |v| + vbus
  logic [23:0] mag_val;
  logic        over;
  logic [16:0] den;

  assign mag_val = test_voltage[23] ? 24'(-test_voltage) : 24'(test_voltage);
  assign over    = mag_val > {1'b0, cfg.voltage_limit, 8'd0};
  assign den     = {item.bus_voltage, 1'b0};

  // divider step
  logic [17:0] div_t;
  logic        div_ge;

  assign div_t  = {rem, quo[15]};
  assign div_ge = div_t >= {1'b0, den};

  // modulation saturation
  logic [16:0] mod_q;

  always_comb begin
    if (item.bus_voltage == 16'd0) mod_q = (mag == 24'd0) ? 17'd0 : 17'd32768;
    else if (ovf)                  mod_q = 17'd65535;
    else                           mod_q = {1'b0, quo};
  end

  // bus current and filtered beta
  logic signed [32:0] bus_p;
  logic signed [24:0] fb_sum;

  assign bus_p  = 33'(last_modulation * alpha_current) + 33'sd16384;
  assign fb_sum = 25'(beta_filter) + 25'sd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_voltage    <= '0;
      beta_filter     <= '0;
      alpha_current   <= '0;
      last_modulation <= '0;
      fault_latched   <= 1'b0;
      div_en          <= 1'b0;
    end else begin
      case (cmd.op)
        prtcl_pkg::OP_CAPTURE: item <= in_item;
        prtcl_pkg::OP_ALPHA:   alpha <= alpha_val;
        prtcl_pkg::OP_BETA:    beta <= sat16(40'($signed(beta_p[34:16])));
        prtcl_pkg::OP_INT_MUL: inc <= 34'(ki) * 34'(err);
        prtcl_pkg::OP_INT_ADD: begin
          if (item.currents_valid) begin
            alpha_current <= alpha;
            if (!fault_latched) test_voltage <= sat24(40'(tv_sum));
          end else begin
            alpha_current <= '0;
            test_voltage  <= '0;
          end
        end
        prtcl_pkg::OP_FILT_MUL: fprod <= 42'(kf) * 42'(fdiff);
        prtcl_pkg::OP_FILT_ADD: begin
          if (item.currents_valid) beta_filter <= sat24(40'(bf_sum));
        end
        prtcl_pkg::OP_CHECK: begin
          mag <= mag_val;
          num <= {mag_val, 8'd0} + {1'b0, mag_val, 7'd0} + {16'd0, item.bus_voltage};
          if (fault_latched || over) begin
            fault_latched   <= 1'b1;
            test_voltage    <= '0;
            last_modulation <= '0;
            fault_now       <= 1'b1;
            div_en          <= 1'b0;
            status_code     <= prtcl_pkg::STATUS_FAULT;
          end else begin
            fault_now   <= 1'b0;
            div_en      <= item.bus_voltage_valid && (item.bus_voltage != 16'd0);
            status_code <= item.bus_voltage_valid ? prtcl_pkg::STATUS_OK
                                                  : prtcl_pkg::STATUS_BUS_INVALID;
          end
        end
        prtcl_pkg::OP_DIV_INIT: begin
          rem <= {1'b0, num[31:16]};
          quo <= num[15:0];
          ovf <= {1'b0, num[31:16]} >= den;
        end
        prtcl_pkg::OP_DIV_STEP: begin
          rem <= div_ge ? 17'(div_t - {1'b0, den}) : div_t[16:0];
          quo <= {quo[14:0], div_ge};
        end
        prtcl_pkg::OP_MOD: begin
          if (!fault_now && item.bus_voltage_valid) begin
            if (test_voltage[23])
              last_modulation <= (mod_q > 17'd32768) ? 16'sh8000 : 16'(-mod_q);
            else
              last_modulation <= (mod_q > 17'd32767) ? 16'sh7fff : 16'(mod_q);
          end
        end
        prtcl_pkg::OP_BUS: bus_i <= sat16(40'($signed(bus_p[32:15])));
        prtcl_pkg::OP_LOAD: begin
          out_item.modulation    <= last_modulation;
          out_item.bus_current   <= bus_i;
          out_item.filtered_beta <= sat16(40'($signed(fb_sum[24:8])));
          out_item.status        <= status_code;
        end
        default: ;
      endcase
    end
  end

  assign stat.skip_div      = !div_en;
  assign stat.fault_latched = fault_latched;

endmodule

>>> src/prtcl_ctrl.sv
module prtcl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  prtcl_pkg::dp_stat_t stat,
  output prtcl_pkg::dp_cmd_t  cmd
);

  localparam int CW = $clog2(prtcl_pkg::DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_ALPHA, S_BETA, S_INT_MUL, S_INT_ADD, S_FILT_MUL, S_FILT_ADD,
    S_CHECK, S_DIV_INIT, S_DIV, S_MOD, S_BUS, S_DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic          out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    unique case (state)
      S_IDLE:     cmd.op = in_valid ? prtcl_pkg::OP_CAPTURE : prtcl_pkg::OP_IDLE;
      S_ALPHA:    cmd.op = prtcl_pkg::OP_ALPHA;
      S_BETA:     cmd.op = prtcl_pkg::OP_BETA;
      S_INT_MUL:  cmd.op = prtcl_pkg::OP_INT_MUL;
      S_INT_ADD:  cmd.op = prtcl_pkg::OP_INT_ADD;
      S_FILT_MUL: cmd.op = prtcl_pkg::OP_FILT_MUL;
      S_FILT_ADD: cmd.op = prtcl_pkg::OP_FILT_ADD;
      S_CHECK:    cmd.op = prtcl_pkg::OP_CHECK;
      S_DIV_INIT: cmd.op = prtcl_pkg::OP_DIV_INIT;
      S_DIV:      cmd.op = prtcl_pkg::OP_DIV_STEP;
      S_MOD:      cmd.op = prtcl_pkg::OP_MOD;
      S_BUS:      cmd.op = prtcl_pkg::OP_BUS;
      S_DONE:     cmd.op = out_free ? prtcl_pkg::OP_LOAD : prtcl_pkg::OP_IDLE;
      default:    cmd.op = prtcl_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:     if (in_valid) state <= S_ALPHA;
        S_ALPHA:    state <= S_BETA;
        S_BETA:     state <= S_INT_MUL;
        S_INT_MUL:  state <= S_INT_ADD;
        S_INT_ADD:  state <= S_FILT_MUL;
        S_FILT_MUL: state <= S_FILT_ADD;
        S_FILT_ADD: state <= S_CHECK;
        S_CHECK:    state <= S_DIV_INIT;
        S_DIV_INIT: begin
          count <= '0;
          state <= stat.skip_div ? S_MOD : S_DIV;
        end
        S_DIV: begin
          count <= count + 1'b1;
          if (count == CW'(prtcl_pkg::DIV_STEPS - 1)) state <= S_MOD;
        end
        S_MOD:      state <= S_BUS;
        S_BUS:      state <= S_DONE;
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/phase_resistance_test_current_loop_core.sv
// channel   dir  handshake              beat
// --------  ---  ---------------------  ----------------------------------------
// in        in   in_valid / in_ready    phase currents, bus voltage, valid flags
// out       out  out_valid / out_ready  modulation, bus current, beta, status
// apb       in   psel/penable/pwrite    four config registers at 4*i, pready=1
//
// one sample at a time: a sample is walked through every step before the
// next accept; the bus voltage divide runs 16 restoring steps, and is skipped
// (fault, bus voltage invalid or zero)
// rst is synchronous and active high, clears config to reset values and the
// loop state (test voltage, filter, alpha, modulation, fault)
// a waiting result sits in the output register; the next sample is taken
// meanwhile, and only the final load stalls until out is free
module phase_resistance_test_current_loop_core (
  input  logic                 clk,
  input  logic                 rst,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  prtcl_pkg::in_item_t  in_item,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output prtcl_pkg::out_item_t out_item,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  prtcl_pkg::cfg_t     cfg;
  prtcl_pkg::dp_cmd_t  cmd;
  prtcl_pkg::dp_stat_t stat;

  // no wait states on the config port
  assign pready = 1'b1;

  // config register file
  prtcl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer: walks clarke, integrator, filter, fault check, divide, outputs
  prtcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and loop state, one operation per command
  prtcl_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

`ifndef ASSERT_OFF
  // a sample in flight blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a sample beat");

  // the overvoltage fault only clears through reset
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(stat.fault_latched))
    else $error("fault latch dropped without reset");

  // a fault result carries zero modulation and matches the latch
  a_fault_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == prtcl_pkg::STATUS_FAULT)
      |-> stat.fault_latched && (out_item.modulation == 16'sd0))
    else $error("fault result without latched fault or with modulation");
`endif

endmodule
